[sv/uac1_control_request_responder_defines.svh]
// ---------------------------------------------------------------------------
// UAC1 control request responder: assertion macros
// Shared assertion forms for the responder RTL.
// ---------------------------------------------------------------------------
`ifndef UAC1_CONTROL_REQUEST_RESPONDER_DEFINES_SVH
`define UAC1_CONTROL_REQUEST_RESPONDER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define UAC1_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define UAC1_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/uac1_pkg.sv]
// ---------------------------------------------------------------------------
// UAC1 responder package
// Item, status and register types plus protocol codes for the responder.
// ---------------------------------------------------------------------------
package uac1_pkg;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 24;

   localparam logic [2:0] FUNC_ENTITY_GET   = 3'd0;
   localparam logic [2:0] FUNC_ENTITY_SET   = 3'd1;
   localparam logic [2:0] FUNC_ENDPOINT_GET = 3'd2;
   localparam logic [2:0] FUNC_ENDPOINT_SET = 3'd3;
   localparam logic [2:0] FUNC_SET_ITF      = 3'd4;

   localparam logic [7:0] ENT_MIC_FU = 8'd2;
   localparam logic [7:0] ENT_SPK_FU = 8'd5;
   localparam logic [7:0] EP_SPK     = 8'h03;
   localparam logic [7:0] EP_MIC     = 8'h83;
   localparam logic [7:0] ITF_SPK    = 8'd3;
   localparam logic [7:0] ITF_MIC    = 8'd4;
   localparam logic [7:0] CS_MUTE    = 8'h01;
   localparam logic [7:0] CS_VOLUME  = 8'h02;
   localparam logic [7:0] CS_FREQ    = 8'h01;

   localparam logic [7:0] RQ_SET_CUR = 8'h01;
   localparam logic [7:0] RQ_GET_CUR = 8'h81;
   localparam logic [7:0] RQ_GET_MIN = 8'h82;
   localparam logic [7:0] RQ_GET_MAX = 8'h83;
   localparam logic [7:0] RQ_GET_RES = 8'h84;

   localparam logic [15:0] LEN_MUTE   = 16'd1;
   localparam logic [15:0] LEN_VOLUME = 16'd2;
   localparam logic [15:0] LEN_RATE   = 16'd3;

   localparam logic [1:0] COUNT_NONE = 2'd0;
   localparam logic [1:0] COUNT_ONE  = 2'd1;
   localparam logic [1:0] COUNT_TWO  = 2'd2;
   localparam logic [1:0] COUNT_RATE = 2'd3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VOLUME_MIN     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VOLUME_MAX     = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VOLUME_STEP    = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SUPPORTED_RATE = 2'd3;

   localparam logic signed [15:0] VOLUME_MIN_RESET = -16'sd15360;
   localparam logic signed [15:0] VOLUME_MAX_RESET = 16'sd0;
   localparam logic [14:0]        VOLUME_STEP_RESET = 15'd256;
   localparam logic [23:0]        RATE_RESET        = 24'd48000;

   typedef struct packed {
      logic [2:0]  func;
      logic [7:0]  request_code;
      logic [15:0] value_word;
      logic [15:0] index_word;
      logic [15:0] length_word;
      logic [23:0] payload;
   } req_item_type;

   typedef struct packed {
      logic signed [15:0] volume_min;
      logic signed [15:0] volume_max;
      logic [14:0]        volume_step;
      logic [23:0]        supported_rate;
   } cfg_type;

   typedef struct packed {
      logic               mic_mute;
      logic               spk_mute;
      logic signed [15:0] mic_gain;
      logic signed [15:0] spk_gain;
      logic [23:0]        mic_rate;
      logic [23:0]        spk_rate;
      logic               mic_active;
      logic               spk_active;
   } state_type;

   typedef struct packed {
      logic               accepted;
      logic [23:0]        reply_bytes;
      logic [1:0]         reply_count;
      logic               mic_is_streaming;
      logic               spk_is_streaming;
      logic               mic_is_muted;
      logic               spk_is_muted;
      logic signed [15:0] mic_volume_now;
      logic signed [15:0] spk_volume_now;
   } rsp_item_type;

endpackage

[sv/uac1_control_request_responder.sv]
// ---------------------------------------------------------------------------
// UAC1 control request responder
// Answers USB Audio Class 1 feature-unit, endpoint and interface requests
// and keeps mute, volume, rate and streaming status for mic and speaker.
// ---------------------------------------------------------------------------
//   channel  direction  handshake            content
//   req_     in         req_valid/req_ready  one control request
//   rsp_     out        rsp_valid/rsp_ready  accept/stall, reply, status
//   csr_     in         csr_valid/csr_ready  register index and data
//
// One request per cycle while the result is not stalled; each request goes
// into the input register, then is decoded into the result register, which
// drives rsp_valid and the rsp_ outputs.
// The status update and the result load happen on the same edge, so the
// next request sees the new status.
// A stalled result holds the input register; csr_ready is always high.
// Synchronous reset clears mute, gain, streaming; loads rate and CSR defaults.
// ---------------------------------------------------------------------------
`include "uac1_control_request_responder_defines.svh"

module uac1_control_request_responder (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [2:0]                            req_func,
   input  logic [7:0]                            req_request_code,
   input  logic [15:0]                           req_value_word,
   input  logic [15:0]                           req_index_word,
   input  logic [15:0]                           req_length_word,
   input  logic [23:0]                           req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_accepted,
   output logic [23:0]                           rsp_reply_bytes,
   output logic [1:0]                            rsp_reply_count,
   output logic                                  rsp_mic_is_streaming,
   output logic                                  rsp_spk_is_streaming,
   output logic                                  rsp_mic_is_muted,
   output logic                                  rsp_spk_is_muted,
   output logic signed [15:0]                    rsp_mic_volume_now,
   output logic signed [15:0]                    rsp_spk_volume_now,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [uac1_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [uac1_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import uac1_pkg::*;

   req_item_type in_item_ff;
   logic         in_valid_ff;
   logic         in_valid_in;
   rsp_item_type out_item_ff;
   rsp_item_type out_item_in;
   logic         out_valid_ff;
   logic         out_valid_in;
   state_type    state_ff;
   state_type    state_in;
   cfg_type      cfg_ff;
   cfg_type      cfg_in;
   req_item_type req_item;
   logic         req_fire;
   logic         advance;

   assign req_item = '{func:         req_func,
                       request_code: req_request_code,
                       value_word:   req_value_word,
                       index_word:   req_index_word,
                       length_word:  req_length_word,
                       payload:      req_payload};

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign req_fire     = req_valid && req_ready;
   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);
   assign csr_ready    = 1'b1;

   uac1_decode u_decode (
      .item (in_item_ff),
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .nxt  (state_in),
      .rsp  (out_item_in)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_VOLUME_MIN:     cfg_in.volume_min     = signed'(csr_data[15:0]);
            CSR_VOLUME_MAX:     cfg_in.volume_max     = signed'(csr_data[15:0]);
            CSR_VOLUME_STEP:    cfg_in.volume_step    = csr_data[14:0];
            CSR_SUPPORTED_RATE: cfg_in.supported_rate = csr_data[23:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{mic_mute: 1'b0, spk_mute: 1'b0,
                           mic_gain: 16'sd0, spk_gain: 16'sd0,
                           mic_rate: RATE_RESET, spk_rate: RATE_RESET,
                           mic_active: 1'b0, spk_active: 1'b0};
         cfg_ff       <= '{volume_min: VOLUME_MIN_RESET, volume_max: VOLUME_MAX_RESET,
                           volume_step: VOLUME_STEP_RESET, supported_rate: RATE_RESET};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_accepted         = out_item_ff.accepted;
   assign rsp_reply_bytes      = out_item_ff.reply_bytes;
   assign rsp_reply_count      = out_item_ff.reply_count;
   assign rsp_mic_is_streaming = out_item_ff.mic_is_streaming;
   assign rsp_spk_is_streaming = out_item_ff.spk_is_streaming;
   assign rsp_mic_is_muted     = out_item_ff.mic_is_muted;
   assign rsp_spk_is_muted     = out_item_ff.spk_is_muted;
   assign rsp_mic_volume_now   = out_item_ff.mic_volume_now;
   assign rsp_spk_volume_now   = out_item_ff.spk_volume_now;

   `UAC1_ASSERT_NOW(a_stall_no_reply, clock, reset, out_valid_ff && !out_item_ff.accepted, out_item_ff.reply_count == COUNT_NONE && out_item_ff.reply_bytes == 24'd0, "stall result carries reply data")
   `UAC1_ASSERT_NEXT(a_item_held, clock, reset, in_valid_ff && out_valid_ff && !rsp_ready, in_valid_ff, "pending item dropped while result stalled")
   `UAC1_ASSERT_NEXT(a_state_quiet, clock, reset, !advance && !reset, $stable(state_ff), "status changed without an item")
   `UAC1_ASSERT_NOW(a_status_match, clock, reset, out_valid_ff, out_item_ff.mic_volume_now == state_ff.mic_gain && out_item_ff.spk_is_muted == state_ff.spk_mute, "result status differs from held status")
endmodule

[sv/uac1_decode.sv]
// ---------------------------------------------------------------------------
// UAC1 request decode
// Decodes one control request against the current status and registers,
// giving the reply and the status that follows it.
// ---------------------------------------------------------------------------
module uac1_decode (
   input  uac1_pkg::req_item_type item,
   input  uac1_pkg::cfg_type      cfg,
   input  uac1_pkg::state_type    cur,
   output uac1_pkg::state_type    nxt,
   output uac1_pkg::rsp_item_type rsp
);
   import uac1_pkg::*;

   logic [7:0]         ctl;
   logic [7:0]         lo_val;
   logic [7:0]         ent;
   logic [7:0]         lo_idx;
   logic               chan_ok;
   logic               ok;
   logic [23:0]        reply;
   logic [1:0]         count;
   logic signed [15:0] vol;
   logic signed [15:0] set_vol;
   logic signed [15:0] clamped;
   logic               mute_val;

   assign ctl      = item.value_word[15:8];
   assign lo_val   = item.value_word[7:0];
   assign ent      = item.index_word[15:8];
   assign lo_idx   = item.index_word[7:0];
   assign chan_ok  = (lo_val <= 8'd1);
   assign set_vol  = signed'(item.payload[15:0]);
   assign mute_val = (item.payload[7:0] != 8'd0);

   always_comb begin
      if (set_vol < cfg.volume_min) begin
         clamped = cfg.volume_min;
      end else if (set_vol > cfg.volume_max) begin
         clamped = cfg.volume_max;
      end else begin
         clamped = set_vol;
      end
   end

   always_comb begin
      nxt   = cur;
      ok    = 1'b0;
      reply = 24'd0;
      count = COUNT_NONE;
      vol   = 16'sd0;
      case (item.func)
         FUNC_ENTITY_GET: begin
            if (chan_ok && ctl == CS_MUTE) begin
               if (ent == ENT_MIC_FU) begin
                  ok    = 1'b1;
                  reply = {23'd0, cur.mic_mute};
                  count = COUNT_ONE;
               end else if (ent == ENT_SPK_FU) begin
                  ok    = 1'b1;
                  reply = {23'd0, cur.spk_mute};
                  count = COUNT_ONE;
               end
            end else if (chan_ok && ctl == CS_VOLUME) begin
               if (item.request_code == RQ_GET_CUR) begin
                  if (ent == ENT_MIC_FU) begin
                     ok  = 1'b1;
                     vol = cur.mic_gain;
                  end else if (ent == ENT_SPK_FU) begin
                     ok  = 1'b1;
                     vol = cur.spk_gain;
                  end
               end else if (item.request_code == RQ_GET_MIN) begin
                  ok  = 1'b1;
                  vol = cfg.volume_min;
               end else if (item.request_code == RQ_GET_MAX) begin
                  ok  = 1'b1;
                  vol = cfg.volume_max;
               end else if (item.request_code == RQ_GET_RES) begin
                  ok  = 1'b1;
                  vol = signed'({1'b0, cfg.volume_step});
               end
               if (ok) begin
                  reply = {8'd0, vol};
                  count = COUNT_TWO;
               end
            end
         end
         FUNC_ENTITY_SET: begin
            if (chan_ok && item.request_code == RQ_SET_CUR) begin
               if (ctl == CS_MUTE && item.length_word == LEN_MUTE) begin
                  if (ent == ENT_MIC_FU) begin
                     ok           = 1'b1;
                     nxt.mic_mute = mute_val;
                  end else if (ent == ENT_SPK_FU) begin
                     ok           = 1'b1;
                     nxt.spk_mute = mute_val;
                  end
               end else if (ctl == CS_VOLUME && item.length_word == LEN_VOLUME) begin
                  if (ent == ENT_MIC_FU) begin
                     ok           = 1'b1;
                     nxt.mic_gain = clamped;
                  end else if (ent == ENT_SPK_FU) begin
                     ok           = 1'b1;
                     nxt.spk_gain = clamped;
                  end
               end
            end
         end
         FUNC_ENDPOINT_GET: begin
            if (ctl == CS_FREQ) begin
               if (lo_idx == EP_SPK) begin
                  ok    = 1'b1;
                  reply = cur.spk_rate;
                  count = COUNT_RATE;
               end else if (lo_idx == EP_MIC) begin
                  ok    = 1'b1;
                  reply = cur.mic_rate;
                  count = COUNT_RATE;
               end
            end
         end
         FUNC_ENDPOINT_SET: begin
            if (ctl == CS_FREQ && item.request_code == RQ_SET_CUR &&
                item.length_word == LEN_RATE && item.payload == cfg.supported_rate) begin
               if (lo_idx == EP_SPK) begin
                  ok           = 1'b1;
                  nxt.spk_rate = item.payload;
               end else if (lo_idx == EP_MIC) begin
                  ok           = 1'b1;
                  nxt.mic_rate = item.payload;
               end
            end
         end
         FUNC_SET_ITF: begin
            if (lo_idx == ITF_SPK) begin
               ok             = 1'b1;
               nxt.spk_active = (lo_val != 8'd0);
            end else if (lo_idx == ITF_MIC) begin
               ok             = 1'b1;
               nxt.mic_active = (lo_val != 8'd0);
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp.accepted         = ok;
      rsp.reply_bytes      = reply;
      rsp.reply_count      = count;
      rsp.mic_is_streaming = nxt.mic_active;
      rsp.spk_is_streaming = nxt.spk_active;
      rsp.mic_is_muted     = nxt.mic_mute;
      rsp.spk_is_muted     = nxt.spk_mute;
      rsp.mic_volume_now   = nxt.mic_gain;
      rsp.spk_volume_now   = nxt.spk_gain;
   end

endmodule

[test/uac1_control_request_responder_test.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// UAC1 control request responder testbench
// Drives feature-unit, endpoint and interface requests through the req_
// channel, predicts each reply and status from its own copy of the mute,
// volume, rate and streaming state, and checks every rsp_ item field by
// field. Register settings change between phases, and sender gaps and
// receiver stalls vary by phase.
// ---------------------------------------------------------------------------
module uac1_control_request_responder_test;
   import uac1_pkg::*;

   localparam logic [2:0] FUNC_UNKNOWN_LO = 3'd5;
   localparam logic [2:0] FUNC_UNKNOWN_HI = 3'd7;
   localparam int         WATCHDOG_LIMIT  = 4000;
   localparam int         HOLD_CYCLES     = 300;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   logic [2:0]                         req_func;
   logic [7:0]                         req_request_code;
   logic [15:0]                        req_value_word;
   logic [15:0]                        req_index_word;
   logic [15:0]                        req_length_word;
   logic [23:0]                        req_payload;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic                               rsp_accepted;
   logic [23:0]                        rsp_reply_bytes;
   logic [1:0]                         rsp_reply_count;
   logic                               rsp_mic_is_streaming;
   logic                               rsp_spk_is_streaming;
   logic                               rsp_mic_is_muted;
   logic                               rsp_spk_is_muted;
   logic signed [15:0]                 rsp_mic_volume_now;
   logic signed [15:0]                 rsp_spk_volume_now;
   logic                               csr_valid;
   logic                               csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]         csr_index;
   logic [CSR_DATA_WIDTH-1:0]          csr_data;

   state_type    device_status;
   cfg_type      device_cfg;
   rsp_item_type expected_answers[$];
   int           mismatch_count = 0;
   int           tx_idle_pct = 0;
   int           rx_stall_pct = 0;
   int           hold_seq = 0;
   int           hold_seen = 0;
   int           hold_left = 0;
   int           idle_cycles = 0;

   uac1_control_request_responder u_dut (.*);

   always #6 clock = ~clock;

   // Predict the answer to one request and advance the status copy.
   function automatic rsp_item_type answer_request(input req_item_type rq);
      logic [7:0]         selector;
      logic [7:0]         channel;
      logic [7:0]         entity;
      logic [7:0]         target;
      logic               ok;
      logic [23:0]        reply;
      logic [1:0]         count;
      logic signed [15:0] level;
      rsp_item_type       r;
      selector = rq.value_word[15:8];
      channel  = rq.value_word[7:0];
      entity   = rq.index_word[15:8];
      target   = rq.index_word[7:0];
      ok       = 1'b0;
      reply    = '0;
      count    = COUNT_NONE;
      level    = '0;
      case (rq.func)
         FUNC_ENTITY_GET: begin
            if (channel <= 8'd1 && selector == CS_MUTE) begin
               if (entity == ENT_MIC_FU) begin
                  ok = 1'b1; reply = {23'd0, device_status.mic_mute}; count = COUNT_ONE;
               end else if (entity == ENT_SPK_FU) begin
                  ok = 1'b1; reply = {23'd0, device_status.spk_mute}; count = COUNT_ONE;
               end
            end else if (channel <= 8'd1 && selector == CS_VOLUME) begin
               if (rq.request_code == RQ_GET_CUR) begin
                  if (entity == ENT_MIC_FU) begin
                     ok = 1'b1; level = device_status.mic_gain;
                  end else if (entity == ENT_SPK_FU) begin
                     ok = 1'b1; level = device_status.spk_gain;
                  end
               end else if (rq.request_code == RQ_GET_MIN) begin
                  ok = 1'b1; level = device_cfg.volume_min;
               end else if (rq.request_code == RQ_GET_MAX) begin
                  ok = 1'b1; level = device_cfg.volume_max;
               end else if (rq.request_code == RQ_GET_RES) begin
                  ok = 1'b1; level = {1'b0, device_cfg.volume_step};
               end
               if (ok) begin
                  reply = {8'd0, level};
                  count = COUNT_TWO;
               end
            end
         end
         FUNC_ENTITY_SET: begin
            if (channel <= 8'd1 && rq.request_code == RQ_SET_CUR) begin
               if (selector == CS_MUTE && rq.length_word == LEN_MUTE) begin
                  if (entity == ENT_MIC_FU) begin
                     ok = 1'b1; device_status.mic_mute = rq.payload[7:0] != 8'd0;
                  end else if (entity == ENT_SPK_FU) begin
                     ok = 1'b1; device_status.spk_mute = rq.payload[7:0] != 8'd0;
                  end
               end else if (selector == CS_VOLUME && rq.length_word == LEN_VOLUME) begin
                  level = rq.payload[15:0];
                  if (level < $signed(device_cfg.volume_min))
                     level = device_cfg.volume_min;
                  else if (level > $signed(device_cfg.volume_max))
                     level = device_cfg.volume_max;
                  if (entity == ENT_MIC_FU) begin
                     ok = 1'b1; device_status.mic_gain = level;
                  end else if (entity == ENT_SPK_FU) begin
                     ok = 1'b1; device_status.spk_gain = level;
                  end
               end
            end
         end
         FUNC_ENDPOINT_GET: begin
            if (selector == CS_FREQ) begin
               if (target == EP_SPK) begin
                  ok = 1'b1; reply = device_status.spk_rate; count = COUNT_RATE;
               end else if (target == EP_MIC) begin
                  ok = 1'b1; reply = device_status.mic_rate; count = COUNT_RATE;
               end
            end
         end
         FUNC_ENDPOINT_SET: begin
            if (selector == CS_FREQ && rq.request_code == RQ_SET_CUR &&
                rq.length_word == LEN_RATE && rq.payload == device_cfg.supported_rate) begin
               if (target == EP_SPK) begin
                  ok = 1'b1; device_status.spk_rate = rq.payload;
               end else if (target == EP_MIC) begin
                  ok = 1'b1; device_status.mic_rate = rq.payload;
               end
            end
         end
         FUNC_SET_ITF: begin
            if (target == ITF_SPK) begin
               ok = 1'b1; device_status.spk_active = channel != 8'd0;
            end else if (target == ITF_MIC) begin
               ok = 1'b1; device_status.mic_active = channel != 8'd0;
            end
         end
         default: ;
      endcase
      if (!ok) begin
         reply = '0;
         count = COUNT_NONE;
      end
      r.accepted         = ok;
      r.reply_bytes      = reply;
      r.reply_count      = count;
      r.mic_is_streaming = device_status.mic_active;
      r.spk_is_streaming = device_status.spk_active;
      r.mic_is_muted     = device_status.mic_mute;
      r.spk_is_muted     = device_status.spk_mute;
      r.mic_volume_now   = device_status.mic_gain;
      r.spk_volume_now   = device_status.spk_gain;
      return r;
   endfunction

   function automatic req_item_type control_request(input logic [2:0] func,
         input logic [7:0] code, input logic [15:0] value, input logic [15:0] index,
         input logic [15:0] length, input logic [23:0] payload);
      req_item_type rq;
      rq.func         = func;
      rq.request_code = code;
      rq.value_word   = value;
      rq.index_word   = index;
      rq.length_word  = length;
      rq.payload      = payload;
      return rq;
   endfunction

   function automatic logic [7:0] pick_byte(input logic [7:0] first, input logic [7:0] second);
      int roll;
      roll = $urandom_range(19);
      if (roll < 9)
         return first;
      else if (roll < 18)
         return second;
      return 8'($urandom_range(255));
   endfunction

   // Mostly well-formed requests with random content, the rest raw noise.
   function automatic req_item_type random_request();
      req_item_type rq;
      rq.func         = 3'($urandom_range(7));
      rq.request_code = 8'($urandom_range(255));
      rq.value_word   = 16'($urandom_range(65535));
      rq.index_word   = 16'($urandom_range(65535));
      rq.length_word  = 16'($urandom_range(65535));
      rq.payload      = 24'($urandom_range(24'hffffff));
      if ($urandom_range(99) < 12)
         return rq;
      rq.func = 3'($urandom_range(FUNC_SET_ITF));
      case (rq.func)
         FUNC_ENTITY_GET, FUNC_ENTITY_SET: begin
            rq.value_word[15:8] = pick_byte(CS_MUTE, CS_VOLUME);
            rq.value_word[7:0]  = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                          : 8'($urandom_range(1));
            rq.index_word[15:8] = pick_byte(ENT_MIC_FU, ENT_SPK_FU);
            if (rq.func == FUNC_ENTITY_GET) begin
               case ($urandom_range(4))
                  0: rq.request_code = RQ_GET_CUR;
                  1: rq.request_code = RQ_GET_MIN;
                  2: rq.request_code = RQ_GET_MAX;
                  3: rq.request_code = RQ_GET_RES;
                  default: ;
               endcase
            end else begin
               if ($urandom_range(9) != 0)
                  rq.request_code = RQ_SET_CUR;
               if ($urandom_range(9) != 0)
                  rq.length_word = (rq.value_word[15:8] == CS_MUTE) ? LEN_MUTE : LEN_VOLUME;
               if ($urandom_range(1))
                  rq.payload[7:0] = 8'd0;
               if ($urandom_range(1))
                  rq.payload[15:0] = 16'(-$urandom_range(16384));
            end
         end
         FUNC_ENDPOINT_GET, FUNC_ENDPOINT_SET: begin
            if ($urandom_range(9) != 0)
               rq.value_word[15:8] = CS_FREQ;
            rq.index_word[7:0] = pick_byte(EP_SPK, EP_MIC);
            if (rq.func == FUNC_ENDPOINT_SET) begin
               if ($urandom_range(9) != 0)
                  rq.request_code = RQ_SET_CUR;
               if ($urandom_range(9) != 0)
                  rq.length_word = LEN_RATE;
               if ($urandom_range(4) != 0)
                  rq.payload = device_cfg.supported_rate;
            end
         end
         default: begin
            rq.index_word[7:0] = pick_byte(ITF_SPK, ITF_MIC);
            if ($urandom_range(1))
               rq.value_word[7:0] = 8'd0;
         end
      endcase
      return rq;
   endfunction

   // Offer one item, with a random gap first, and hold it until accepted.
   task automatic send_request(input req_item_type rq);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_valid        <= 1'b1;
      req_func         <= rq.func;
      req_request_code <= rq.request_code;
      req_value_word   <= rq.value_word;
      req_index_word   <= rq.index_word;
      req_length_word  <= rq.length_word;
      req_payload      <= rq.payload;
      do @(posedge clock); while (!req_ready);
      expected_answers.push_back(answer_request(rq));
   endtask

   task automatic wait_all_answered();
      req_valid <= 1'b0;
      while (expected_answers.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic post_register(input logic [CSR_INDEX_WIDTH-1:0] index,
         input logic [CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_VOLUME_MIN:     device_cfg.volume_min     = data[15:0];
         CSR_VOLUME_MAX:     device_cfg.volume_max     = data[15:0];
         CSR_VOLUME_STEP:    device_cfg.volume_step    = data[14:0];
         CSR_SUPPORTED_RATE: device_cfg.supported_rate = data[23:0];
         default: ;
      endcase
   endtask

   // Write all registers while idle; unused upper data bits carry noise.
   task automatic write_settings(input logic [15:0] vmin, input logic [15:0] vmax,
         input logic [14:0] step, input logic [23:0] rate);
      logic [23:0] noise;
      wait_all_answered();
      noise = 24'($urandom_range(24'hffffff));
      post_register(CSR_VOLUME_MIN, {noise[23:16], vmin});
      post_register(CSR_VOLUME_MAX, {noise[15:8], vmax});
      post_register(CSR_VOLUME_STEP, {noise[23:15], step});
      post_register(CSR_SUPPORTED_RATE, rate);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random_items(input int count, input int tx_pct, input int rx_pct);
      tx_idle_pct  = tx_pct;
      rx_stall_pct = rx_pct;
      repeat (count) send_request(random_request());
   endtask

   task automatic test_directed_requests();
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      send_request(control_request(FUNC_ENTITY_GET, RQ_GET_CUR, {CS_MUTE, 8'd0},
                                   {ENT_MIC_FU, 8'd0}, LEN_MUTE, 24'd0));
      send_request(control_request(FUNC_ENTITY_GET, 8'h00, {CS_MUTE, 8'd1},
                                   {ENT_SPK_FU, 8'hff}, 16'hffff, 24'hffffff));
      send_request(control_request(FUNC_ENTITY_GET, RQ_GET_CUR, {CS_MUTE, 8'd0},
                                   {8'hff, 8'd0}, LEN_MUTE, 24'd0));
      send_request(control_request(FUNC_ENTITY_GET, RQ_GET_CUR, {CS_MUTE, 8'd2},
                                   {ENT_MIC_FU, 8'd0}, LEN_MUTE, 24'd0));
      send_request(control_request(FUNC_ENTITY_GET, RQ_GET_CUR, {CS_VOLUME, 8'd0},
                                   {ENT_SPK_FU, 8'd0}, LEN_VOLUME, 24'd0));
      send_request(control_request(FUNC_ENTITY_GET, RQ_GET_CUR, {CS_VOLUME, 8'd1},
                                   {8'd0, 8'd0}, LEN_VOLUME, 24'd0));
      send_request(control_request(FUNC_ENTITY_GET, RQ_GET_MIN, {CS_VOLUME, 8'd0},
                                   {8'hff, 8'hff}, LEN_VOLUME, 24'd0));
      send_request(control_request(FUNC_ENTITY_GET, RQ_GET_MAX, {CS_VOLUME, 8'd1},
                                   {8'd0, 8'd0}, 16'd0, 24'd0));
      send_request(control_request(FUNC_ENTITY_GET, RQ_GET_RES, {CS_VOLUME, 8'd0},
                                   {8'hff, 8'd0}, LEN_VOLUME, 24'd0));
      send_request(control_request(FUNC_ENTITY_GET, 8'hff, {CS_VOLUME, 8'd0},
                                   {ENT_MIC_FU, 8'd0}, LEN_VOLUME, 24'd0));
      send_request(control_request(FUNC_ENTITY_GET, RQ_GET_CUR, {8'hff, 8'd0},
                                   {ENT_MIC_FU, 8'd0}, LEN_VOLUME, 24'd0));
      send_request(control_request(FUNC_ENTITY_SET, RQ_SET_CUR, {CS_MUTE, 8'd0},
                                   {ENT_MIC_FU, 8'd0}, LEN_MUTE, 24'hffff00));
      send_request(control_request(FUNC_ENTITY_SET, RQ_SET_CUR, {CS_MUTE, 8'd1},
                                   {ENT_SPK_FU, 8'd0}, LEN_MUTE, 24'h000080));
      send_request(control_request(FUNC_ENTITY_SET, RQ_SET_CUR, {CS_MUTE, 8'd0},
                                   {ENT_MIC_FU, 8'd0}, 16'd0, 24'h000001));
      send_request(control_request(FUNC_ENTITY_SET, RQ_SET_CUR, {CS_VOLUME, 8'd0},
                                   {ENT_SPK_FU, 8'd0}, LEN_VOLUME, 24'h008000));
      send_request(control_request(FUNC_ENTITY_SET, RQ_SET_CUR, {CS_VOLUME, 8'd1},
                                   {ENT_MIC_FU, 8'd0}, LEN_VOLUME, 24'hff7fff));
      send_request(control_request(FUNC_ENTITY_SET, RQ_GET_CUR, {CS_VOLUME, 8'hff},
                                   {ENT_MIC_FU, 8'd0}, LEN_VOLUME, 24'h000100));
      send_request(control_request(FUNC_ENDPOINT_GET, 8'hff, {CS_FREQ, 8'd0},
                                   {8'd0, EP_MIC}, LEN_RATE, 24'd0));
      send_request(control_request(FUNC_ENDPOINT_GET, 8'h00, {CS_FREQ, 8'd0},
                                   {8'd0, 8'd0}, LEN_RATE, 24'd0));
      send_request(control_request(FUNC_ENDPOINT_SET, RQ_SET_CUR, {CS_FREQ, 8'd0},
                                   {8'd0, EP_SPK}, LEN_RATE, RATE_RESET));
      send_request(control_request(FUNC_ENDPOINT_SET, RQ_SET_CUR, {CS_FREQ, 8'd0},
                                   {8'd0, EP_MIC}, LEN_RATE, RATE_RESET + 24'd1));
      send_request(control_request(FUNC_ENDPOINT_SET, RQ_SET_CUR, {CS_FREQ, 8'd0},
                                   {8'd0, 8'hff}, LEN_RATE, RATE_RESET));
      send_request(control_request(FUNC_SET_ITF, 8'd0, {8'd0, 8'hff},
                                   {8'd0, ITF_MIC}, 16'd0, 24'd0));
      send_request(control_request(FUNC_SET_ITF, 8'd0, {8'd0, 8'd1},
                                   {8'd0, ITF_SPK}, 16'd0, 24'd0));
      send_request(control_request(FUNC_SET_ITF, 8'd0, {8'd0, 8'd1},
                                   {8'd0, 8'd0}, 16'd0, 24'd0));
      send_request(control_request(FUNC_UNKNOWN_LO, RQ_SET_CUR, {CS_MUTE, 8'd0},
                                   {ENT_MIC_FU, ITF_MIC}, LEN_MUTE, 24'h000001));
      send_request(control_request(FUNC_UNKNOWN_HI, 8'hff, 16'hffff,
                                   16'hffff, 16'hffff, 24'hffffff));
   endtask

   task automatic test_register_extremes();
      write_settings(16'h8000, 16'h7fff, 15'h7fff, 24'hffffff);
      run_random_items(20, 24, 24);
      write_settings(16'd1000, -16'sd1000, 15'd0, 24'd0);
      run_random_items(20, 24, 24);
      write_settings(16'h7fff, 16'h8000, 15'd1, 24'd1);
      run_random_items(20, 24, 24);
      write_settings(-16'sd5, -16'sd5, 15'd256, RATE_RESET);
      run_random_items(20, 24, 24);
      write_settings(VOLUME_MIN_RESET, VOLUME_MAX_RESET, VOLUME_STEP_RESET, RATE_RESET);
      run_random_items(20, 24, 24);
   endtask

   task automatic test_idling_phases();
      run_random_items(100, 0, 0);
      write_settings(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                     15'($urandom_range(32767)), RATE_RESET);
      run_random_items(100, 84, 0);
      write_settings(16'(-$urandom_range(20000)), 16'($urandom_range(20000)),
                     15'($urandom_range(32767)), 24'($urandom_range(24'hffffff)));
      run_random_items(100, 0, 84);
      write_settings(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                     15'($urandom_range(32767)), RATE_RESET);
      run_random_items(100, 24, 24);
   endtask

   // Stall the result side for a long stretch while items keep coming.
   task automatic test_result_backpressure();
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      hold_seq <= hold_seq + 1;
      repeat (20) send_request(random_request());
      wait_all_answered();
   endtask

   task automatic compare_field(input string name, input logic [23:0] want,
         input logic [23:0] seen);
      if (want !== seen) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= $urandom_range(99) >= rx_stall_pct;
      end
   end

   always @(posedge clock) begin : check_results
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_answers.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual accepted %b reply %h",
                     $time, rsp_accepted, rsp_reply_bytes);
            mismatch_count++;
         end else begin
            want = expected_answers.pop_front();
            compare_field("accepted", 24'(want.accepted), 24'(rsp_accepted));
            compare_field("reply_bytes", want.reply_bytes, rsp_reply_bytes);
            compare_field("reply_count", 24'(want.reply_count), 24'(rsp_reply_count));
            compare_field("mic_is_streaming", 24'(want.mic_is_streaming),
                          24'(rsp_mic_is_streaming));
            compare_field("spk_is_streaming", 24'(want.spk_is_streaming),
                          24'(rsp_spk_is_streaming));
            compare_field("mic_is_muted", 24'(want.mic_is_muted), 24'(rsp_mic_is_muted));
            compare_field("spk_is_muted", 24'(want.spk_is_muted), 24'(rsp_spk_is_muted));
            compare_field("mic_volume_now", 24'(want.mic_volume_now),
                          24'(rsp_mic_volume_now));
            compare_field("spk_volume_now", 24'(want.spk_volume_now),
                          24'(rsp_spk_volume_now));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, idle_cycles);
         $display("uac1_control_request_responder test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_func         <= '0;
      req_request_code <= '0;
      req_value_word   <= '0;
      req_index_word   <= '0;
      req_length_word  <= '0;
      req_payload      <= '0;
      csr_valid        <= 1'b0;
      csr_index        <= '0;
      csr_data         <= '0;
      device_cfg.volume_min       = VOLUME_MIN_RESET;
      device_cfg.volume_max       = VOLUME_MAX_RESET;
      device_cfg.volume_step      = VOLUME_STEP_RESET;
      device_cfg.supported_rate   = RATE_RESET;
      device_status.mic_mute      = 1'b0;
      device_status.spk_mute      = 1'b0;
      device_status.mic_gain      = '0;
      device_status.spk_gain      = '0;
      device_status.mic_rate      = RATE_RESET;
      device_status.spk_rate      = RATE_RESET;
      device_status.mic_active    = 1'b0;
      device_status.spk_active    = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed_requests();
      test_register_extremes();
      test_idling_phases();
      test_result_backpressure();
      wait_all_answered();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("uac1_control_request_responder test passed");
      else
         $display("uac1_control_request_responder test failed");
      $finish;
   end

endmodule
